// ===== rtl/core/direct_address_symbol_table_core_macros.svh =====
// Assertion macros for the direct-address table RTL.
`ifndef DIRECT_ADDRESS_SYMBOL_TABLE_CORE_MACROS_SVH
`define DIRECT_ADDRESS_SYMBOL_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define DAST_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DAST_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `DAST_ASSERT(label, clk, rst_n, !(cond), msg)
`else
`define DAST_ASSERT(label, clk, rst_n, prop, msg)
`define DAST_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/core/dast_pkg.sv =====
// Package with the action codes and sequencer states of the direct-address table.
package dast_pkg;

    localparam int KEY_W   = 8;
    localparam int VALUE_W = 32;
    localparam int RANK_W  = 8;
    localparam int COUNT_W = 9;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_SELECT = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/core/dast_value_ram.sv =====
// Single-port value memory with a registered read port.
module dast_value_ram
    import dast_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic               clk,
    input  logic               en,
    input  logic               we,
    input  logic [AW-1:0]      addr,
    input  logic [VALUE_W-1:0] wdata,
    output logic [VALUE_W-1:0] rdata
);

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/direct_address_symbol_table_core.sv =====
// Top level of the direct-address table: sequencer, occupied marks and result register.
//
// Direct-address table of min(TABLE_SIZE, 256) entries, each a 32-bit signed
// value with an occupied mark, addressed by the key index itself. Insert,
// search and delete pass through the transfer cycle, in which the value
// memory is written or read and the marks and count are updated, and the
// hand-off state, which passes the result to the output register. Select
// walks the occupied marks from key 0 upward, one mark per cycle, through a
// single index counter and a rank down-counter; a hit at key i passes the
// transfer cycle, a scan of keys 0 to i and the hand-off state, and a rank
// that is never reached scans the full depth. The value memory is a
// single-port array with a registered read, allowing one access per cycle.
// The output register parts the two channels: a finished result may wait
// there while the next item is already taken and worked on. No new input
// is taken while an item is in the scan or hand-off state, and the hand-off
// state holds while the output register is still full. The occupied marks
// are flip-flops cleared at reset, so no clearing pass is needed and the
// block is ready from the first cycle after reset. Each result carries the
// occupied count after its action; it changes only when an insert hits an
// empty entry or a delete hits an occupied one. Keys at or beyond the table
// depth are ignored by insert and delete and reported as not found.
`include "direct_address_symbol_table_core_macros.svh"

module direct_address_symbol_table_core
    import dast_pkg::*;
#(
    parameter int TABLE_SIZE = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic [KEY_W-1:0]   key_index,
    input  logic signed [VALUE_W-1:0] value,
    input  logic [RANK_W-1:0]  rank,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               found,
    output logic [KEY_W-1:0]   entry_key,
    output logic signed [VALUE_W-1:0] entry_value,
    output logic [COUNT_W-1:0] occupied_count
);

    // Keys are eight bits wide, so no entry past 255 can ever be occupied.
    localparam int DEPTH = (TABLE_SIZE < 256) ? TABLE_SIZE : 256;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [KEY_W:0]   DEPTH_K   = (KEY_W+1)'(DEPTH);
    localparam logic [AW-1:0]    LAST_IX   = AW'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(DEPTH);

    state_t state_reg, state_next;

    logic [DEPTH-1:0]   marks_reg, marks_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [RANK_W-1:0]  left_reg, left_next;

    // Result of the current item, held until the output register is free.
    logic             res_found_reg, res_found_next;
    logic [KEY_W-1:0] res_key_reg, res_key_next;
    logic             res_mem_reg, res_mem_next;

    logic               out_valid_reg, out_valid_next;
    logic               found_reg, found_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [COUNT_W-1:0] ocount_reg, ocount_next;

    logic               ram_en;
    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [VALUE_W-1:0] ram_rdata;

    logic          accept;
    logic          in_table;
    logic [AW-1:0] key_ix;
    logic          key_mark;
    logic          scan_mark;
    logic          scan_hit;
    logic          scan_last;
    logic          out_free;

    assign key_ix    = key_index[AW-1:0];
    assign in_table  = {1'b0, key_index} < DEPTH_K;
    assign key_mark  = marks_reg[key_ix];
    assign scan_mark = marks_reg[idx_reg];
    assign scan_hit  = (state_reg == ST_SCAN) && scan_mark && (left_reg == '0);
    assign scan_last = (idx_reg == LAST_IX);
    assign out_free  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (action_t'(action) == ACT_SELECT) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (scan_hit || scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs and datapath next values.
    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE);
        marks_next     = marks_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        left_next      = left_reg;
        res_found_next = res_found_reg;
        res_key_next   = res_key_reg;
        res_mem_next   = res_mem_reg;
        out_valid_next = out_valid_reg && !out_ready;
        found_next     = found_reg;
        key_next       = key_reg;
        value_next     = value_reg;
        ocount_next    = ocount_reg;
        ram_en         = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = key_ix;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_found_next = 1'b0;
                    res_key_next   = key_index;
                    res_mem_next   = 1'b0;
                    unique case (action_t'(action))
                        ACT_INSERT:
                        begin
                            if (in_table)
                            begin
                                ram_en = 1'b1;
                                ram_we = 1'b1;
                                if (!key_mark)
                                begin
                                    marks_next[key_ix] = 1'b1;
                                    count_next         = count_reg + 1'b1;
                                end
                            end
                        end
                        ACT_SEARCH:
                        begin
                            if (in_table && key_mark)
                            begin
                                ram_en         = 1'b1;
                                res_found_next = 1'b1;
                                res_mem_next   = 1'b1;
                            end
                        end
                        ACT_DELETE:
                        begin
                            // The stale value stays; it is only read while occupied.
                            if (in_table && key_mark)
                            begin
                                marks_next[key_ix] = 1'b0;
                                count_next         = count_reg - 1'b1;
                            end
                        end
                        ACT_SELECT:
                        begin
                            idx_next  = '0;
                            left_next = rank;
                        end
                        default:
                        begin
                            idx_next = '0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                ram_addr = idx_reg;
                if (scan_hit)
                begin
                    ram_en         = 1'b1;
                    res_found_next = 1'b1;
                    res_key_next   = KEY_W'(idx_reg);
                    res_mem_next   = 1'b1;
                end
                else
                begin
                    if (scan_mark)
                    begin
                        left_next = left_reg - 1'b1;
                    end
                    if (scan_last)
                    begin
                        res_found_next = 1'b0;
                        res_key_next   = '0;
                        res_mem_next   = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = res_found_reg;
                    key_next       = res_key_reg;
                    value_next     = res_mem_reg ? ram_rdata : '0;
                    ocount_next    = count_reg;
                end
            end
            default:
            begin
                ram_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            marks_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            marks_reg     <= marks_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        left_reg      <= left_next;
        res_found_reg <= res_found_next;
        res_key_reg   <= res_key_next;
        res_mem_reg   <= res_mem_next;
        found_reg     <= found_next;
        key_reg       <= key_next;
        value_reg     <= value_next;
        ocount_reg    <= ocount_next;
    end

    dast_value_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_value_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (value),
        .rdata (ram_rdata)
    );

    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign entry_key      = key_reg;
    assign entry_value    = value_reg;
    assign occupied_count = ocount_reg;

    // The occupied count can never pass the table depth.
    `DAST_ASSERT(a_count_bound, clk, rst_n, count_reg <= COUNT_MAX, "occupied count overflow")
    // The count moves by at most one per cycle.
    `DAST_ASSERT(a_count_step, clk, rst_n, (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 1'b1) || (count_reg == $past(count_reg) - 1'b1), "count jumped")
    // A new result only enters the output register from the hand-off state.
    `DAST_ASSERT(a_load_from_done, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == ST_DONE), "result loaded outside hand-off")
    // An insert that lands in the table leaves its entry occupied.
    `DAST_ASSERT(a_insert_marks, clk, rst_n, (accept && (action_t'(action) == ACT_INSERT) && in_table) |=> marks_reg[$past(key_ix)], "insert left entry empty")

endmodule
